[design/tccs_pkg.sv]
// shared constants and types for the text console cursor and scroll unit
package tccs_pkg;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 64;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET = 7'd25;

  localparam logic [1:0] FUNC_PUT  = 2'd0;
  localparam logic [1:0] FUNC_DEL  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_capture;
    logic clear_step;
    logic scroll_step;
    logic blank_step;
  } tccs_cmd_t;

  typedef struct packed {
    logic is_read;
    logic need_scroll;
    logic clear_last;
    logic copy_done;
    logic blank_last;
  } tccs_sts_t;

endpackage

[design/tccs_ctrl.sv]
// control state machine of the text console unit
module tccs_ctrl import tccs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  tccs_sts_t sts_i,
  output tccs_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_RDATA  = 7'b0001000,
    ST_SCROLL = 7'b0010000,
    ST_BLANK  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_read) state_d = ST_RDATA;
        else if (sts_i.need_scroll) state_d = ST_SCROLL;
        else state_d = ST_DONE;
      end
      ST_RDATA: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = ST_DONE;
      end
      ST_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
        if (sts_i.copy_done) state_d = ST_BLANK;
      end
      ST_BLANK: begin
        cmd_o.blank_step = 1'b1;
        if (sts_i.blank_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

[design/tccs_dpath.sv]
// cursor, configuration registers and cell memory of the text console unit
module tccs_dpath import tccs_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic [1:0] func_i,
  input  logic [7:0] char_code_i,
  input  logic [6:0] read_col_i,
  input  logic [5:0] read_row_i,
  input  tccs_cmd_t  cmd_i,
  output tccs_sts_t  sts_o,
  output logic [6:0] cursor_col_o,
  output logic [5:0] cursor_row_o,
  output logic       scrolled_o,
  output logic [7:0] cell_char_o
);

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  function automatic logic [CW:0] eff_cols(logic [7:0] v);
    if (v == 8'd0) return (CW + 1)'(1);
    if (32'(v) > MAX_COLS) return (CW + 1)'(MAX_COLS);
    return (CW + 1)'(v);
  endfunction

  function automatic logic [RW:0] eff_rows(logic [6:0] v);
    if (v == 7'd0) return (RW + 1)'(1);
    if (32'(v) > MAX_ROWS) return (RW + 1)'(MAX_ROWS);
    return (RW + 1)'(v);
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [RW-1:0] r, logic [CW-1:0] c);
    return AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  logic [7:0]    cols_q;
  logic [6:0]    rows_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [1:0]    func_q;
  logic [7:0]    char_q;
  logic [AW-1:0] rd_addr_q;
  logic          rd_inside_q;
  logic          scrolled_q;
  logic [7:0]    cell_q;
  logic [AW-1:0] ptr_q;
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]    rdata_q;
  logic [7:0]    cell_mem_q [DEPTH];

  logic [CW:0]   cols_eff, col_inc, new_cols;
  logic [RW:0]   rows_eff, row_inc, new_rows;
  logic [CW-1:0] col_max, del_col;
  logic [RW-1:0] row_max, del_row;
  logic          put_nl, put_scroll, del_move, is_put, is_del;
  logic [AW-1:0] n_end, last_blank, raddr, waddr;
  logic [7:0]    wdata;
  logic          we;

  assign cols_eff   = eff_cols(cols_q);
  assign rows_eff   = eff_rows(rows_q);
  assign col_max    = CW'(cols_eff - (CW + 1)'(1));
  assign row_max    = RW'(rows_eff - (RW + 1)'(1));
  assign col_inc    = {1'b0, col_q} + (CW + 1)'(1);
  assign row_inc    = {1'b0, row_q} + (RW + 1)'(1);
  assign is_put     = (func_q == FUNC_PUT);
  assign is_del     = (func_q == FUNC_DEL);
  assign put_nl     = (char_q == CH_NEWLINE) || (col_inc >= cols_eff);
  assign put_scroll = put_nl && (row_inc >= rows_eff);
  assign del_move   = (col_q != '0) || (row_q != '0);
  assign del_col    = (col_q == '0) ? col_max : col_q - CW'(1);
  assign del_row    = (col_q == '0) ? row_q - RW'(1) : row_q;
  assign n_end      = AW'(32'(row_max) * MAX_COLS);
  assign last_blank = AW'(32'(rows_eff) * MAX_COLS - 1);
  assign new_cols   = eff_cols(cfg_data_i);
  assign new_rows   = eff_rows(cfg_data_i[6:0]);

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = CH_SPACE;
    if (cmd_i.clear_step || cmd_i.blank_step) begin
      we = 1'b1;
    end else if (cmd_i.exec) begin
      case (func_q)
        FUNC_PUT: begin
          if (char_q != CH_NEWLINE) begin
            we    = 1'b1;
            waddr = addr_of(row_q, col_q);
            wdata = char_q;
          end
        end
        FUNC_DEL: begin
          if (del_move) begin
            we    = 1'b1;
            waddr = addr_of(del_row, del_col);
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end else if (cmd_i.scroll_step && wr_pend_q) begin
      we    = 1'b1;
      waddr = wr_addr_q;
      wdata = rdata_q;
    end
  end

  assign raddr = cmd_i.scroll_step ? ptr_q + AW'(MAX_COLS) : rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      cell_mem_q[waddr] <= wdata;
    end
    rdata_q <= cell_mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q      <= func_i;
      char_q      <= char_code_i;
      rd_inside_q <= (32'(read_col_i) < MAX_COLS) && (32'(read_row_i) < MAX_ROWS);
      rd_addr_q   <= AW'(32'(read_row_i) * MAX_COLS + 32'(read_col_i));
    end
    if (cmd_i.scroll_step && ptr_q != n_end) begin
      wr_addr_q <= ptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= COLS_RESET;
      rows_q     <= ROWS_RESET;
      col_q      <= '0;
      row_q      <= '0;
      scrolled_q <= 1'b0;
      cell_q     <= '0;
      ptr_q      <= '0;
      wr_pend_q  <= 1'b0;
    end else begin
      // register write saturates the cursor into the new grid
      if (cfg_we_i) begin
        if (cfg_index_i == REG_COLS) begin
          cols_q <= cfg_data_i;
          if ({1'b0, col_q} >= new_cols) col_q <= CW'(new_cols - (CW + 1)'(1));
        end else begin
          rows_q <= cfg_data_i[6:0];
          if ({1'b0, row_q} >= new_rows) row_q <= RW'(new_rows - (RW + 1)'(1));
        end
      end
      if (cmd_i.load) begin
        scrolled_q <= 1'b0;
        cell_q     <= '0;
      end
      if (cmd_i.exec) begin
        ptr_q     <= '0;
        wr_pend_q <= 1'b0;
        if (is_put) begin
          scrolled_q <= put_scroll;
          if (put_nl) begin
            col_q <= '0;
            row_q <= put_scroll ? row_max : RW'(row_inc);
          end else begin
            col_q <= CW'(col_inc);
          end
        end else if (is_del && del_move) begin
          col_q <= del_col;
          row_q <= del_row;
        end
      end
      if (cmd_i.rd_capture) begin
        cell_q <= rd_inside_q ? rdata_q : CH_SPACE;
      end
      if (cmd_i.clear_step || cmd_i.blank_step) begin
        ptr_q <= ptr_q + AW'(1);
      end
      if (cmd_i.scroll_step) begin
        if (ptr_q != n_end) begin
          wr_pend_q <= 1'b1;
          ptr_q     <= ptr_q + AW'(1);
        end else begin
          wr_pend_q <= 1'b0;
        end
      end
    end
  end

  assign sts_o.is_read     = (func_q == FUNC_READ);
  assign sts_o.need_scroll = is_put && put_scroll;
  assign sts_o.clear_last  = (ptr_q == LAST_ADDR);
  assign sts_o.copy_done   = (ptr_q == n_end) && !wr_pend_q;
  assign sts_o.blank_last  = (ptr_q == last_blank);

  assign cursor_col_o = 7'(col_q);
  assign cursor_row_o = 6'(row_q);
  assign scrolled_o   = scrolled_q;
  assign cell_char_o  = cell_q;

endmodule

[design/text_console_cursor_scroll_unit.sv]
// top level of the text console cursor and scroll unit
// After reset the unit sweeps the whole cell memory to spaces, one cell per cycle,
// and holds busy_o high meanwhile; register writes are meant to be made only while
// no command is in flight, which the block itself does not enforce (cfg_ready_o is
// tied high). A command is taken when start_i is high and busy_o is low. A put or
// delete goes through the execute state to done_o, a read also through a state for
// the registered memory read. A put that moves past the last row also scrolls: the
// single cell memory copies one cell per cycle and then blanks the bottom row,
// MAX_COLS cells, also one per cycle. done_o marks the result for exactly one cycle
// and cannot be held off, so the receiver must take it then.
module text_console_cursor_scroll_unit import tccs_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] func_i,
  input  logic [7:0] char_code_i,
  input  logic [6:0] read_col_i,
  input  logic [5:0] read_row_i,
  output logic       done_o,
  output logic [6:0] cursor_col_o,
  output logic [5:0] cursor_row_o,
  output logic       scrolled_o,
  output logic [7:0] cell_char_o
);

  tccs_cmd_t cmd;
  tccs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tccs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  tccs_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .read_col_i   (read_col_i),
    .read_row_i   (read_row_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .scrolled_o   (scrolled_o),
    .cell_char_o  (cell_char_o)
  );

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe while idle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o)) else $error("command transfer lost");

  a_scroll_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && scrolled_o) |-> (cell_char_o == 8'h00)) else $error("scroll with cell data");

endmodule
